FILE: src/pidfan_pkg.sv
// Package for the PID fan temperature controller: widths, register indexes, constants.
package pidfan_pkg;

    localparam int TEMP_W      = 12;
    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 16;
    localparam int WINDUP_W    = 15;
    localparam int INTEG_W     = 16;
    localparam int ERR_W       = TEMP_W + 1;
    localparam int DERR_W      = ERR_W + 1;
    localparam int SPEED_W     = 7;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int RAW_W       = 34;

    localparam int GAIN_FRAC_BITS = 8;

    localparam logic signed [TEMP_W-1:0]   TEMP_LOW       = -12'sd800;
    localparam logic signed [TEMP_W-1:0]   TEMP_HIGH      = 12'sd1600;
    localparam logic [SPEED_W-1:0]         SPEED_MAX      = 7'd99;

    localparam logic signed [TEMP_W-1:0]   TARGET_RESET   = 12'sd400;
    localparam logic signed [DRIVE_W-1:0]  DRIVE_MIN_RESET = -16'sd1600;
    localparam logic signed [DRIVE_W-1:0]  DRIVE_MAX_RESET = 16'sd1600;
    localparam logic [WINDUP_W-1:0]        WINDUP_RESET   = 15'd800;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_TARGET_TEMP  = 3'd3,
        REG_DRIVE_MIN    = 3'd4,
        REG_DRIVE_MAX    = 3'd5,
        REG_WINDUP_LIMIT = 3'd6
    } cfg_reg_t;

endpackage

FILE: src/pid_fan_temperature_controller_top.sv
// Top level of the PID fan temperature controller.
// A sample passes through the input register, then the result register, to m_axis.
// Throughput: one transaction per cycle unless m_axis_tready stalls; unless a sample is rejected,
// integral and previous error update in the same cycle the result loads, so the next sample sees them.
// Reset (aresetn low, synchronous) clears valids and state, and loads the
// default gains, setpoint, drive range and windup limit.
module pid_fan_temperature_controller_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [pidfan_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pidfan_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [pidfan_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [11:0] sample_temp
    input  logic                                  s_axis_tuser,  // [0] sensor_fault
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pidfan_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [6:0] fan_speed, [22:7] control_output
    output logic                                  m_axis_tuser   // [0] fault_seen
);

    localparam int TW = pidfan_pkg::TEMP_W;
    localparam int GW = pidfan_pkg::GAIN_W;
    localparam int DW = pidfan_pkg::DRIVE_W;
    localparam int WW = pidfan_pkg::WINDUP_W;
    localparam int IW = pidfan_pkg::INTEG_W;
    localparam int EW = pidfan_pkg::ERR_W;
    localparam int XW = pidfan_pkg::DERR_W;
    localparam int SW = pidfan_pkg::SPEED_W;
    localparam int RW = pidfan_pkg::RAW_W;

    // configuration
    logic signed [GW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [TW-1:0] target_reg;
    logic signed [DW-1:0] drive_min_reg, drive_max_reg;
    logic [WW-1:0]        windup_reg;

    // state
    logic signed [IW-1:0] integ_reg, integ_next;
    logic signed [EW-1:0] prev_err_reg;

    // input stage
    logic                 in_valid_reg;
    logic signed [TW-1:0] in_sample_reg;
    logic                 in_fault_reg;

    // result stage
    logic                 out_valid_reg;
    logic [SW-1:0]        out_speed_reg, out_speed_next;
    logic                 out_fault_reg, out_fault_next;
    logic signed [DW-1:0] out_ctrl_reg, out_ctrl_next;

    logic out_ready, advance, reject;

    logic signed [EW-1:0]   err;
    logic signed [IW:0]     integ_sum, windup_pos, windup_neg, integ_clamped;
    logic signed [XW-1:0]   derr;
    logic signed [GW+EW-1:0] prod_p;
    logic signed [GW+IW-1:0] prod_i;
    logic signed [GW+XW-1:0] prod_d;
    logic signed [RW-1:0]   raw_sum, raw_shift;
    logic signed [DW-1:0]   ctrl_val;
    logic signed [DW:0]     ctrl_neg;
    logic [DW-4:0]          speed_wide;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    assign reject = in_fault_reg || (in_sample_reg < pidfan_pkg::TEMP_LOW)
                    || (in_sample_reg > pidfan_pkg::TEMP_HIGH);

    always_comb begin
        err        = EW'(target_reg) - EW'(in_sample_reg);
        integ_sum  = (IW+1)'(integ_reg) + (IW+1)'(err);
        windup_pos = signed'({2'b00, windup_reg});
        windup_neg = -windup_pos;
        if (integ_sum > windup_pos) begin
            integ_clamped = windup_pos;
        end else if (integ_sum < windup_neg) begin
            integ_clamped = windup_neg;
        end else begin
            integ_clamped = integ_sum;
        end
        integ_next = integ_clamped[IW-1:0];
        derr       = XW'(err) - XW'(prev_err_reg);
        prod_p     = gain_p_reg * err;
        prod_i     = gain_i_reg * integ_next;
        prod_d     = gain_d_reg * derr;
        raw_sum    = RW'(prod_p) + RW'(prod_i) + RW'(prod_d);
        raw_shift  = raw_sum >>> pidfan_pkg::GAIN_FRAC_BITS;
        if (raw_shift > RW'(drive_max_reg)) begin
            ctrl_val = drive_max_reg;
        end else if (raw_shift < RW'(drive_min_reg)) begin
            ctrl_val = drive_min_reg;
        end else begin
            ctrl_val = raw_shift[DW-1:0];
        end
        ctrl_neg   = -((DW+1)'(ctrl_val));
        speed_wide = ctrl_neg[DW:4];
        if (reject) begin
            out_speed_next = '0;
            out_fault_next = 1'b1;
            out_ctrl_next  = '0;
        end else begin
            out_fault_next = 1'b0;
            out_ctrl_next  = ctrl_val;
            if (!ctrl_val[DW-1]) begin
                out_speed_next = '0;
            end else if (speed_wide > (DW-3)'(pidfan_pkg::SPEED_MAX)) begin
                out_speed_next = pidfan_pkg::SPEED_MAX;
            end else begin
                out_speed_next = speed_wide[SW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            target_reg    <= pidfan_pkg::TARGET_RESET;
            drive_min_reg <= pidfan_pkg::DRIVE_MIN_RESET;
            drive_max_reg <= pidfan_pkg::DRIVE_MAX_RESET;
            windup_reg    <= pidfan_pkg::WINDUP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pidfan_pkg::REG_GAIN_P:       gain_p_reg    <= cfg_wdata;
                pidfan_pkg::REG_GAIN_I:       gain_i_reg    <= cfg_wdata;
                pidfan_pkg::REG_GAIN_D:       gain_d_reg    <= cfg_wdata;
                pidfan_pkg::REG_TARGET_TEMP:  target_reg    <= cfg_wdata[TW-1:0];
                pidfan_pkg::REG_DRIVE_MIN:    drive_min_reg <= cfg_wdata;
                pidfan_pkg::REG_DRIVE_MAX:    drive_max_reg <= cfg_wdata;
                pidfan_pkg::REG_WINDUP_LIMIT: windup_reg    <= cfg_wdata[WW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && !reject) begin
                integ_reg    <= integ_next;
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_sample_reg <= s_axis_tdata[TW-1:0];
            in_fault_reg  <= s_axis_tuser;
        end
        if (advance) begin
            out_speed_reg <= out_speed_next;
            out_fault_reg <= out_fault_next;
            out_ctrl_reg  <= out_ctrl_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_ctrl_reg, out_speed_reg};
    assign m_axis_tuser  = out_fault_reg;

endmodule

FILE: src/pidfan_checker.sv
// Port-level checker for the PID fan temperature controller, with its bind.
module pidfan_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pidfan_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("rejected sample with nonzero result");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= pidfan_pkg::SPEED_MAX))
        else $error("fan speed above limit");

    a_speed_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[6:0] != '0)) |-> m_axis_tdata[22])
        else $error("fan running with nonnegative drive");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                              && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind pid_fan_temperature_controller_top pidfan_checker u_pidfan_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
